### src/pulse_width_remote_code_decoder_defines.svh
// ---------------------------------------------------------------------------
// Pulse-width remote code decoder: assertion macros
// Shared concurrent assertion helpers, clocked on clk_i and gated by rst_ni.
// ---------------------------------------------------------------------------
`ifndef PULSE_WIDTH_REMOTE_CODE_DECODER_DEFINES_SVH
`define PULSE_WIDTH_REMOTE_CODE_DECODER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PWRCD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PWRCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/pwrcd_pkg.sv
// ---------------------------------------------------------------------------
// Pulse-width remote code decoder package
// Widths, fixed protocol constants and register indexes.
// ---------------------------------------------------------------------------
`default_nettype none

package pwrcd_pkg;

  localparam int unsigned DurW   = 24;
  localparam int unsigned TimeW  = 16;
  localparam int unsigned CountW = 6;
  localparam int unsigned IdxW   = 8;
  localparam int unsigned CfgW   = 32;

  // The preamble is a low lasting 56 short times, matched within 52 tolerances.
  localparam logic [7:0] PreambleTimes = 8'd56;
  localparam logic [7:0] PreambleTols  = 8'd52;
  localparam logic [CountW-1:0] CountMax = 6'd63;

  // Register indexes on the configuration channel.
  localparam logic [IdxW-1:0] CfgShortTime = 8'd0;
  localparam logic [IdxW-1:0] CfgLongTime  = 8'd1;
  localparam logic [IdxW-1:0] CfgTolerance = 8'd2;
  localparam logic [IdxW-1:0] CfgGap       = 8'd3;
  localparam logic [IdxW-1:0] CfgLengthA   = 8'd4;
  localparam logic [IdxW-1:0] CfgLengthB   = 8'd5;
  localparam logic [IdxW-1:0] CfgLengthC   = 8'd6;
  localparam logic [IdxW-1:0] CfgLengthD   = 8'd7;

  // Register values after reset.
  localparam logic [TimeW-1:0]  RstShortTime = 16'd320;
  localparam logic [TimeW-1:0]  RstLongTime  = 16'd640;
  localparam logic [TimeW-1:0]  RstTolerance = 16'd150;
  localparam logic [DurW-1:0]   RstGap       = 24'd5000;
  localparam logic [CountW-1:0] RstLengthA   = 6'd12;
  localparam logic [CountW-1:0] RstLengthB   = 6'd18;
  localparam logic [CountW-1:0] RstLengthC   = 6'd25;
  localparam logic [CountW-1:0] RstLengthD   = 6'd24;

endpackage

`default_nettype wire

### src/pwrcd_near.sv
// ---------------------------------------------------------------------------
// Duration window compare
// Flags a duration whose absolute distance from a nominal is below a tolerance.
// ---------------------------------------------------------------------------
`default_nettype none

module pwrcd_near (
  input  wire logic [pwrcd_pkg::DurW-1:0] dur_i,
  input  wire logic [pwrcd_pkg::DurW-1:0] nominal_i,
  input  wire logic [pwrcd_pkg::DurW-1:0] tol_i,
  output logic                            hit_o
);

  logic [pwrcd_pkg::DurW-1:0] diff;

  always_comb begin
    if (dur_i > nominal_i) begin
      diff = dur_i - nominal_i;
    end else begin
      diff = nominal_i - dur_i;
    end
    hit_o = (diff < tol_i);
  end

endmodule

`default_nettype wire

### src/pulse_width_remote_code_decoder.sv
// A pulse that ends a frame of a wanted length loads its code word into the output register.
// Throughput: one pulse per cycle; the single registered update of the decoder state
// sets that figure, and the pulse register stalls only while a code word waits at the output.
// Reset: rst_ni is asynchronous, active low; the decoder returns to waiting for a preamble,
// all timing and length registers take their default values, and no transfer is pending.
// ---------------------------------------------------------------------------
// Pulse-width remote code decoder (top level)
// Turns a stream of level/duration pulses into remote-control code words.
// ---------------------------------------------------------------------------
`default_nettype none
`include "pulse_width_remote_code_decoder_defines.svh"

module pulse_width_remote_code_decoder #(
  parameter int unsigned CODE_WIDTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Pulse input stream.
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [23:0] s_axis_tdata_i,   // [23:0] duration
  input  wire logic        s_axis_tuser_i,   // [0] level (1 high, 0 low)
  // Code word output stream.
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [39:0]      m_axis_tdata_o,   // [31:0] code, [37:32] bit_count, [39:38] zero
  // Configuration write channel.
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);

  localparam int unsigned DurW   = pwrcd_pkg::DurW;
  localparam int unsigned CountW = pwrcd_pkg::CountW;

  // Decoder phases.
  localparam logic [1:0] PhReset = 2'd0;  // waiting for the long low preamble
  localparam logic [1:0] PhStart = 2'd1;  // waiting for the short high start bit
  localparam logic [1:0] PhLow   = 2'd2;  // expecting the low half of a bit, or the gap
  localparam logic [1:0] PhHigh  = 2'd3;  // expecting the high half of a bit

  // ---------------------------------------------------------------------
  // Configuration registers. Writes are always taken; unknown indexes are
  // dropped.
  // ---------------------------------------------------------------------
  logic [pwrcd_pkg::TimeW-1:0] short_q, long_q, tol_q;
  logic [DurW-1:0]             gap_q;
  logic [CountW-1:0]           len_a_q, len_b_q, len_c_q, len_d_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_q <= pwrcd_pkg::RstShortTime;
      long_q  <= pwrcd_pkg::RstLongTime;
      tol_q   <= pwrcd_pkg::RstTolerance;
      gap_q   <= pwrcd_pkg::RstGap;
      len_a_q <= pwrcd_pkg::RstLengthA;
      len_b_q <= pwrcd_pkg::RstLengthB;
      len_c_q <= pwrcd_pkg::RstLengthC;
      len_d_q <= pwrcd_pkg::RstLengthD;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        pwrcd_pkg::CfgShortTime: short_q <= cfg_data_i[15:0];
        pwrcd_pkg::CfgLongTime:  long_q  <= cfg_data_i[15:0];
        pwrcd_pkg::CfgTolerance: tol_q   <= cfg_data_i[15:0];
        pwrcd_pkg::CfgGap:       gap_q   <= cfg_data_i[23:0];
        pwrcd_pkg::CfgLengthA:   len_a_q <= cfg_data_i[5:0];
        pwrcd_pkg::CfgLengthB:   len_b_q <= cfg_data_i[5:0];
        pwrcd_pkg::CfgLengthC:   len_c_q <= cfg_data_i[5:0];
        pwrcd_pkg::CfgLengthD:   len_d_q <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Pulse register. It takes a new pulse whenever it is empty or its
  // current pulse is consumed in this cycle, so pulses stream back to back.
  // ---------------------------------------------------------------------
  logic            in_vld_q;
  logic            in_level_q;
  logic [DurW-1:0] in_dur_q;
  logic            advance;   // the held pulse updates the decoder this cycle
  logic            emit;      // the held pulse completes a frame of a wanted length
  logic            out_free;  // the output register can take a code word

  assign out_free        = !m_axis_tvalid_o || m_axis_tready_i;
  assign advance         = in_vld_q && (!emit || out_free);
  assign s_axis_tready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_level_q <= s_axis_tuser_i;
      in_dur_q   <= s_axis_tdata_i;
    end
  end

  // ---------------------------------------------------------------------
  // Duration windows. The preamble nominal and tolerance are constant
  // multiples of the configured values; both fit in 22 bits.
  // ---------------------------------------------------------------------
  logic [DurW-1:0] short_w, long_w, tol_w, pre_nom, pre_tol;
  logic            pre_hit, dur_short, dur_long, low_short, low_long;
  logic [DurW-1:0] last_low_q, last_low_d;

  assign short_w = {{(DurW-pwrcd_pkg::TimeW){1'b0}}, short_q};
  assign long_w  = {{(DurW-pwrcd_pkg::TimeW){1'b0}}, long_q};
  assign tol_w   = {{(DurW-pwrcd_pkg::TimeW){1'b0}}, tol_q};
  assign pre_nom = short_w * DurW'(pwrcd_pkg::PreambleTimes);
  assign pre_tol = tol_w * DurW'(pwrcd_pkg::PreambleTols);

  pwrcd_near u_near_pre (
    .dur_i(in_dur_q), .nominal_i(pre_nom), .tol_i(pre_tol), .hit_o(pre_hit)
  );
  pwrcd_near u_near_dur_short (
    .dur_i(in_dur_q), .nominal_i(short_w), .tol_i(tol_w), .hit_o(dur_short)
  );
  pwrcd_near u_near_dur_long (
    .dur_i(in_dur_q), .nominal_i(long_w), .tol_i(tol_w), .hit_o(dur_long)
  );
  pwrcd_near u_near_low_short (
    .dur_i(last_low_q), .nominal_i(short_w), .tol_i(tol_w), .hit_o(low_short)
  );
  pwrcd_near u_near_low_long (
    .dur_i(last_low_q), .nominal_i(long_w), .tol_i(tol_w), .hit_o(low_long)
  );

  // ---------------------------------------------------------------------
  // Decoder state update.
  // ---------------------------------------------------------------------
  logic [1:0]            phase_q, phase_d;
  logic [CODE_WIDTH-1:0] shift_q, shift_d;
  logic [CountW-1:0]     bits_q, bits_d;
  logic                  len_match;

  assign len_match = (bits_q == len_a_q) || (bits_q == len_b_q) ||
                     (bits_q == len_c_q) || (bits_q == len_d_q);

  always_comb begin
    phase_d    = phase_q;
    shift_d    = shift_q;
    bits_d     = bits_q;
    last_low_d = last_low_q;
    emit       = 1'b0;
    case (phase_q)
      PhReset: begin
        if (!in_level_q && pre_hit) begin
          phase_d = PhStart;
        end
      end
      PhStart: begin
        // A low while waiting for the start bit leaves the phase alone.
        if (in_level_q) begin
          if (dur_short) begin
            phase_d = PhLow;
            shift_d = '0;
            bits_d  = '0;
          end else begin
            phase_d = PhReset;
          end
        end
      end
      PhLow: begin
        if (in_level_q) begin
          phase_d = PhReset;
        end else if (in_dur_q > gap_q) begin
          // End of frame: the code and count stay until the next start bit.
          phase_d = PhStart;
          emit    = len_match;
        end else begin
          last_low_d = in_dur_q;
          phase_d    = PhHigh;
        end
      end
      PhHigh: begin
        if (in_level_q && low_short && dur_long) begin
          shift_d = {shift_q[CODE_WIDTH-2:0], 1'b0};
          bits_d  = (bits_q < pwrcd_pkg::CountMax) ? bits_q + 1'b1 : bits_q;
          phase_d = PhLow;
        end else if (in_level_q && low_long && dur_short) begin
          shift_d = {shift_q[CODE_WIDTH-2:0], 1'b1};
          bits_d  = (bits_q < pwrcd_pkg::CountMax) ? bits_q + 1'b1 : bits_q;
          phase_d = PhLow;
        end else begin
          phase_d = PhReset;
        end
      end
      default: phase_d = PhReset;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhReset;
      shift_q    <= '0;
      bits_q     <= '0;
      last_low_q <= '0;
    end else if (advance) begin
      phase_q    <= phase_d;
      shift_q    <= shift_d;
      bits_q     <= bits_d;
      last_low_q <= last_low_d;
    end
  end

  // ---------------------------------------------------------------------
  // Output register. The code carries the low 32 bits of the shift
  // register, zero extended when the shift register is narrower.
  // ---------------------------------------------------------------------
  logic [31:0] code_w;

  if (CODE_WIDTH >= 32) begin : g_code_wide
    assign code_w = shift_q[31:0];
  end else begin : g_code_narrow
    assign code_w = {{(32-CODE_WIDTH){1'b0}}, shift_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid_o <= 1'b0;
    end else if (advance && emit) begin
      m_axis_tvalid_o <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_axis_tvalid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      m_axis_tdata_o <= {2'b00, bits_q, code_w};
    end
  end

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  `PWRCD_ASSERT_SAME(a_emit_in_low, advance && emit, phase_q == PhLow,
                     "code word produced outside the low phase")
  `PWRCD_ASSERT_NEXT(a_emit_loads_out, advance && emit, m_axis_tvalid_o,
                     "emitted code word did not reach the output register")
  `PWRCD_ASSERT_SAME(a_stall_cause, in_vld_q && !advance,
                     m_axis_tvalid_o && !m_axis_tready_i,
                     "pulse stalled while the output was free")
  `PWRCD_ASSERT_NEXT(a_start_clears, advance && phase_q == PhStart && phase_d == PhLow,
                     bits_q == '0 && shift_q == '0,
                     "start bit did not clear the frame")

endmodule

`default_nettype wire
